FILE: design/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared widths, types and state codes of the continued fraction expander.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  // Data width of the numeric words; the partial remainder has one bit more
  localparam int WIDTH       = 32;
  // Hard cap on results per input fraction
  localparam int MAX_RESULTS = 48;
  // Bit counter of the shift-subtract divider
  localparam int CNT_W       = $clog2(WIDTH);
  // Result counter within one run
  localparam int RES_W       = $clog2(MAX_RESULTS);

  typedef logic [WIDTH-1:0] word_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_EMIT = 4'b0100,
    S_ERR  = 4'b1000
  } state_t;

  // Working set of one divide / multiply-accumulate iteration
  typedef struct packed {
    logic [WIDTH:0] rem;    // partial remainder
    word_t          quo;    // dividend bits shifting out, quotient bits in
    word_t          acc_p;  // running quotient * p_{k-1}
    word_t          acc_q;  // running quotient * q_{k-1}
  } step_t;

endpackage

`default_nettype wire

FILE: design/cfc_if.sv
// ----------------------------------------------------------------------------
// cfc_in_if / cfc_out_if
// Valid/ready channels carrying input fractions and expansion results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfc_in_if;
  logic                 valid;
  logic                 ready;
  cfc_pkg::word_t       numerator;
  cfc_pkg::word_t       denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface cfc_out_if;
  logic                 valid;
  logic                 ready;
  cfc_pkg::word_t       partial_quotient;
  cfc_pkg::word_t       conv_numerator;
  cfc_pkg::word_t       conv_denominator;
  cfc_pkg::word_t       common_divisor;
  logic                 is_last;
  logic                 error;

  modport source (output valid, output partial_quotient, output conv_numerator,
                  output conv_denominator, output common_divisor,
                  output is_last, output error, input ready);
  modport sink   (input valid, input partial_quotient, input conv_numerator,
                  input conv_denominator, input common_divisor,
                  input is_last, input error, output ready);
endinterface

`default_nettype wire

FILE: design/cfc_step_unit.sv
// ----------------------------------------------------------------------------
// cfc_step_unit
// One iteration of restoring division, fused with MSB-first shift-add
// multiplication of the emerging quotient by the previous convergent terms.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_step_unit (
  input  var cfc_pkg::step_t cur,
  input  var cfc_pkg::word_t divisor,
  input  var cfc_pkg::word_t p_prev,
  input  var cfc_pkg::word_t q_prev,
  output var cfc_pkg::step_t nxt
);

  logic [cfc_pkg::WIDTH:0] shifted;
  logic [cfc_pkg::WIDTH:0] div_ext;
  logic                    ge;

  // Bring down the next dividend bit and trial-subtract
  assign shifted = {cur.rem[cfc_pkg::WIDTH-1:0], cur.quo[cfc_pkg::WIDTH-1]};
  assign div_ext = {1'b0, divisor};
  assign ge      = (shifted >= div_ext);

  always_comb begin
    nxt.rem   = ge ? (shifted - div_ext) : shifted;
    nxt.quo   = {cur.quo[cfc_pkg::WIDTH-2:0], ge};
    // Horner step: acc = 2*acc + bit*term
    nxt.acc_p = {cur.acc_p[cfc_pkg::WIDTH-2:0], 1'b0} + (ge ? p_prev : '0);
    nxt.acc_q = {cur.acc_q[cfc_pkg::WIDTH-2:0], 1'b0} + (ge ? q_prev : '0);
  end

endmodule

`default_nettype wire

FILE: design/continued_fraction_convergents.sv
// ----------------------------------------------------------------------------
// continued_fraction_convergents
// Expands numerator/denominator into its simple continued fraction and
// emits each partial quotient together with the convergent p_k/q_k.
//
// Input channel in_ch: one fraction per transfer. Output channel out_ch:
// one result per partial quotient; the last one has is_last set and carries
// the gcd, unless the run is cut at MAX_RESULTS results (gcd zero then).
// A zero denominator yields a single result with error set. Each quotient
// comes from a shift-subtract divider that also builds a_k*p_{k-1} and
// a_k*q_{k-1} bit by bit; after the division the sequencer adds p_{k-2}
// and q_{k-2} and loads the output register. A run has at most 46 quotients
// for 32-bit inputs.
// in_ch.ready is high only between runs; the next fraction can be taken while
// the final result still waits in the output register.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits before loading the next one.
// Reset (rst_n low, synchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module continued_fraction_convergents (
  input  wire        clk,
  input  wire        rst_n,
  cfc_in_if.sink     in_ch,
  cfc_out_if.source  out_ch
);

  cfc_pkg::state_t           state_r, state_nxt;
  cfc_pkg::step_t            step_r, step_nxt, step_calc;
  cfc_pkg::word_t            y_r, y_nxt;
  cfc_pkg::word_t            p1_r, p1_nxt, p2_r, p2_nxt;
  cfc_pkg::word_t            q1_r, q1_nxt, q2_r, q2_nxt;
  logic [cfc_pkg::CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [cfc_pkg::RES_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  cfc_pkg::word_t            out_pq_r, out_pq_nxt;
  cfc_pkg::word_t            out_cn_r, out_cn_nxt;
  cfc_pkg::word_t            out_cd_r, out_cd_nxt;
  cfc_pkg::word_t            out_gcd_r, out_gcd_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_err_r, out_err_nxt;

  logic                      in_xfer;
  logic                      out_free;
  cfc_pkg::word_t            p_new, q_new, rem_w;
  logic                      run_done, run_cut;

  // Shared divide / multiply-accumulate iteration
  cfc_step_unit u_step (
    .cur     (step_r),
    .divisor (y_r),
    .p_prev  (p1_r),
    .q_prev  (q1_r),
    .nxt     (step_calc)
  );

  assign in_ch.ready = (state_r == cfc_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Finish the convergent terms and classify the step
  assign p_new    = step_r.acc_p + p2_r;
  assign q_new    = step_r.acc_q + q2_r;
  assign rem_w    = step_r.rem[cfc_pkg::WIDTH-1:0];
  assign run_done = (rem_w == '0);
  assign run_cut  = !run_done && (res_cnt_r == cfc_pkg::RES_W'(cfc_pkg::MAX_RESULTS - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    y_nxt         = y_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    q1_nxt        = q1_r;
    q2_nxt        = q2_r;
    bit_cnt_nxt   = bit_cnt_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pq_nxt    = out_pq_r;
    out_cn_nxt    = out_cn_r;
    out_cd_nxt    = out_cd_r;
    out_gcd_nxt   = out_gcd_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      cfc_pkg::S_IDLE: begin
        // Seed the recurrence: p = 0, 1 and q = 1, 0
        if (in_xfer) begin
          step_nxt.rem   = '0;
          step_nxt.quo   = in_ch.numerator;
          step_nxt.acc_p = '0;
          step_nxt.acc_q = '0;
          y_nxt          = in_ch.denominator;
          p1_nxt         = cfc_pkg::word_t'(1);
          p2_nxt         = '0;
          q1_nxt         = '0;
          q2_nxt         = cfc_pkg::word_t'(1);
          bit_cnt_nxt    = '0;
          res_cnt_nxt    = '0;
          state_nxt      = (in_ch.denominator == '0) ? cfc_pkg::S_ERR : cfc_pkg::S_DIV;
        end
      end

      cfc_pkg::S_DIV: begin
        // Advance one quotient bit
        step_nxt    = step_calc;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == cfc_pkg::CNT_W'(cfc_pkg::WIDTH - 1)) begin
          state_nxt = cfc_pkg::S_EMIT;
        end
      end

      cfc_pkg::S_EMIT: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pq_nxt    = step_r.quo;
          out_cn_nxt    = p_new;
          out_cd_nxt    = q_new;
          out_gcd_nxt   = run_done ? y_r : '0;
          out_last_nxt  = run_done || run_cut;
          out_err_nxt   = 1'b0;
          if (run_done || run_cut) begin
            state_nxt = cfc_pkg::S_IDLE;
          end else begin
            // Shift the Euclid pair and the convergent history
            p2_nxt         = p1_r;
            p1_nxt         = p_new;
            q2_nxt         = q1_r;
            q1_nxt         = q_new;
            step_nxt.rem   = '0;
            step_nxt.quo   = y_r;
            step_nxt.acc_p = '0;
            step_nxt.acc_q = '0;
            y_nxt          = rem_w;
            bit_cnt_nxt    = '0;
            res_cnt_nxt    = res_cnt_r + 1'b1;
            state_nxt      = cfc_pkg::S_DIV;
          end
        end
      end

      cfc_pkg::S_ERR: begin
        // Zero denominator: single flagged result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pq_nxt    = '0;
          out_cn_nxt    = '0;
          out_cd_nxt    = '0;
          out_gcd_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = cfc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cfc_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    y_r       <= y_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    q1_r      <= q1_nxt;
    q2_r      <= q2_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_pq_r  <= out_pq_nxt;
    out_cn_r  <= out_cn_nxt;
    out_cd_r  <= out_cd_nxt;
    out_gcd_r <= out_gcd_nxt;
    out_last_r <= out_last_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.partial_quotient = out_pq_r;
  assign out_ch.conv_numerator   = out_cn_r;
  assign out_ch.conv_denominator = out_cd_r;
  assign out_ch.common_divisor   = out_gcd_r;
  assign out_ch.is_last          = out_last_r;
  assign out_ch.error            = out_err_r;

endmodule

`default_nettype wire

FILE: design/cfc_checker.sv
// ----------------------------------------------------------------------------
// cfc_checker
// Port-level checks of the continued fraction expander, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire cfc_pkg::word_t out_pq,
  input wire cfc_pkg::word_t out_cn,
  input wire cfc_pkg::word_t out_cd,
  input wire cfc_pkg::word_t out_gcd,
  input wire                 out_last,
  input wire                 out_error
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The block is busy right after taking a fraction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // An error result is final and carries only zeros
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_pq == '0) && (out_cn == '0) &&
                               (out_cd == '0) && (out_gcd == '0))
    else $error("malformed error result");

  // Only the final result carries a gcd
  a_gcd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_gcd == '0) && !out_error)
    else $error("gcd or error on an intermediate result");

endmodule

bind continued_fraction_convergents cfc_checker u_cfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pq    (out_ch.partial_quotient),
  .out_cn    (out_ch.conv_numerator),
  .out_cd    (out_ch.conv_denominator),
  .out_gcd   (out_ch.common_divisor),
  .out_last  (out_ch.is_last),
  .out_error (out_ch.error)
);

`default_nettype wire
